// ----- rtl/websocket_frame_decoder_core_defines.svh -----
// Assertion macros for the RTL files; only wfd_queue uses them.
`ifndef WEBSOCKET_FRAME_DECODER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_DECODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("websocket frame decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define WFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("websocket frame decoder check failed");

`endif

// ----- rtl/wfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wfd_pkg;

  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [QUEUE_AW-1:0] PTR_ONE  = QUEUE_AW'(1);
  localparam logic [QUEUE_CW-1:0] CNT_ONE  = QUEUE_CW'(1);
  localparam logic [QUEUE_CW-1:0] CNT_FULL = QUEUE_CW'(QUEUE_DEPTH);

  typedef struct packed {
    logic        kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] payload_length;
    logic [7:0]  raw_byte;
    logic [7:0]  key_byte;
    logic        frame_end;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// ----- rtl/wfd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wfd_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_byte,
  input  wire wfd_pkg::queue_status_t q_status,
  output logic                       push,
  output wfd_pkg::entry_t            entry
);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD
  } phase_t;

  phase_t      phase, phase_next;
  logic        fin, fin_next;
  logic [3:0]  opcode, opcode_next;
  logic        masked, masked_next;
  logic [3:0]  hdr_count, hdr_count_next;
  logic [63:0] frame_length, frame_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_pos, mask_pos_next;
  logic [63:0] bytes_left, bytes_left_next;

  logic        fire;
  logic        finish;
  logic [3:0]  count_dec;
  logic [6:0]  len7;
  logic [7:0]  key_sel;

  assign in_stall  = q_status.full;
  assign fire      = in_valid & ~q_status.full;
  assign count_dec = hdr_count - 4'd1;
  assign len7      = in_byte[6:0];
  assign key_sel   = mask_key[{~mask_pos, 3'b000} +: 8];

  always_comb begin
    phase_next        = phase;
    fin_next          = fin;
    opcode_next       = opcode;
    masked_next       = masked;
    hdr_count_next    = hdr_count;
    frame_length_next = frame_length;
    mask_key_next     = mask_key;
    mask_pos_next     = mask_pos;
    bytes_left_next   = bytes_left;
    finish            = 1'b0;
    push              = 1'b0;
    entry             = '0;

    if (fire) begin
      case (phase)
        PH_SECOND: begin
          masked_next = in_byte[7];
          if (len7 == wfd_pkg::LEN16_CODE) begin
            frame_length_next = '0;
            hdr_count_next    = wfd_pkg::EXT16_BYTES;
            phase_next        = PH_EXTLEN;
          end else if (len7 == wfd_pkg::LEN64_CODE) begin
            frame_length_next = '0;
            hdr_count_next    = wfd_pkg::EXT64_BYTES;
            phase_next        = PH_EXTLEN;
          end else begin
            frame_length_next = {57'd0, len7};
            if (in_byte[7]) begin
              hdr_count_next = wfd_pkg::KEY_BYTES;
              phase_next     = PH_MASK;
            end else begin
              finish = 1'b1;
            end
          end
        end
        PH_EXTLEN: begin
          frame_length_next = {frame_length[55:0], in_byte};
          hdr_count_next    = count_dec;
          if (count_dec == 4'd0) begin
            if (masked) begin
              hdr_count_next = wfd_pkg::KEY_BYTES;
              phase_next     = PH_MASK;
            end else begin
              finish = 1'b1;
            end
          end
        end
        PH_MASK: begin
          mask_key_next  = {mask_key[23:0], in_byte};
          hdr_count_next = count_dec;
          if (count_dec == 4'd0) begin
            finish = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          mask_pos_next        = mask_pos + 2'd1;
          bytes_left_next      = bytes_left - 64'd1;
          push                 = 1'b1;
          entry.kind           = wfd_pkg::KIND_PAYLOAD;
          entry.fin            = fin;
          entry.opcode         = opcode;
          entry.masked         = masked;
          entry.payload_length = frame_length;
          entry.raw_byte       = in_byte;
          entry.key_byte       = key_sel;
          entry.frame_end      = (bytes_left == 64'd1);
          if (bytes_left == 64'd1) begin
            phase_next = PH_FIRST;
          end
        end
        default: begin
          fin_next          = in_byte[7];
          opcode_next       = in_byte[3:0];
          masked_next       = 1'b0;
          hdr_count_next    = '0;
          frame_length_next = '0;
          mask_key_next     = '0;
          mask_pos_next     = '0;
          bytes_left_next   = '0;
          phase_next        = PH_SECOND;
        end
      endcase

      if (finish) begin
        bytes_left_next      = frame_length_next;
        mask_pos_next        = '0;
        push                 = 1'b1;
        entry.kind           = wfd_pkg::KIND_HEADER;
        entry.fin            = fin_next;
        entry.opcode         = opcode_next;
        entry.masked         = masked_next;
        entry.payload_length = frame_length_next;
        entry.frame_end      = (frame_length_next == 64'd0);
        phase_next           = (frame_length_next == 64'd0) ? PH_FIRST : PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
    end else begin
      phase <= phase_next;
    end
    fin          <= fin_next;
    opcode       <= opcode_next;
    masked       <= masked_next;
    hdr_count    <= hdr_count_next;
    frame_length <= frame_length_next;
    mask_key     <= mask_key_next;
    mask_pos     <= mask_pos_next;
    bytes_left   <= bytes_left_next;
  end

endmodule

`default_nettype wire

// ----- rtl/wfd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "websocket_frame_decoder_core_defines.svh"

module wfd_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire wfd_pkg::entry_t        push_entry,
  input  wire logic                   pop,
  output wfd_pkg::entry_t             head,
  output wfd_pkg::queue_status_t      status
);

  wfd_pkg::entry_t                 slots [wfd_pkg::QUEUE_DEPTH];
  logic [wfd_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [wfd_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [wfd_pkg::QUEUE_CW-1:0]    count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == wfd_pkg::CNT_FULL);
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + wfd_pkg::PTR_ONE;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + wfd_pkg::PTR_ONE;
      end
      if (push && !pop) begin
        count <= count + wfd_pkg::CNT_ONE;
      end else if (pop && !push) begin
        count <= count - wfd_pkg::CNT_ONE;
      end
    end
  end

  `WFD_ASSERT_SAME(a_no_push_when_full, clk, rst, status.full, !push)
  `WFD_ASSERT_SAME(a_no_pop_when_empty, clk, rst, status.empty, !pop)
  `WFD_ASSERT_SAME(a_count_bounded, clk, rst, 1'b1, count <= wfd_pkg::CNT_FULL)
  `WFD_ASSERT_NEXT(a_push_grows, clk, rst, push && !pop, count == $past(count) + wfd_pkg::CNT_ONE)

endmodule

`default_nettype wire

// ----- rtl/wfd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wfd_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire wfd_pkg::entry_t        head,
  input  wire wfd_pkg::queue_status_t q_status,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        kind,
  output logic                        fin,
  output logic [3:0]                  opcode,
  output logic                        masked,
  output logic [63:0]                 payload_length,
  output logic [7:0]                  payload_byte,
  output logic                        frame_end
);

  assign pop = ~q_status.empty & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (pop) begin
      kind           <= head.kind;
      fin            <= head.fin;
      opcode         <= head.opcode;
      masked         <= head.masked;
      payload_length <= head.payload_length;
      payload_byte   <= head.raw_byte ^ head.key_byte;
      frame_end      <= head.frame_end;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/websocket_frame_decoder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Parses a WebSocket byte stream, one word of one byte each cycle while in_stall is low.
// The input channel takes stream bytes on in_byte with in_valid and in_stall.
// The output channel gives one word per header and one per payload byte:
// kind is 0 for a header word and 1 for a payload word, payload_byte holds
// the unmasked byte, and frame_end marks the last word of a frame.
// A byte that completes a header or carries payload gives its word, through a
// queue slot and then the output register, on the output ports; other header bytes give none.
// Throughput is one byte per cycle while in_stall is low; a four-word queue
// lies between the header parser and the output register.
// When the receiver stalls, the output word holds, the queue fills, and after
// four more words in_stall rises until the receiver takes words again.
// Reset empties the queue and the output register and makes the next byte
// the first byte of a new frame header.
module websocket_frame_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic             fin,
  output logic [3:0]       opcode,
  output logic             masked,
  output logic [63:0]      payload_length,
  output logic [7:0]       payload_byte,
  output logic             frame_end
);

  logic                   push;
  logic                   pop;
  wfd_pkg::entry_t        push_entry;
  wfd_pkg::entry_t        head;
  wfd_pkg::queue_status_t q_status;

  wfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_status (q_status),
    .push     (push),
    .entry    (push_entry)
  );

  wfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  wfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .fin            (fin),
    .opcode         (opcode),
    .masked         (masked),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .frame_end      (frame_end)
  );

endmodule

`default_nettype wire

// ----- tb/websocket_frame_decoder_core_tb.sv -----
`timescale 1ns / 1ps

module websocket_frame_decoder_core_tb;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic        kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] payload_length;
    logic [7:0]  payload_byte;
    logic        frame_end;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_FIRST,
    ST_SECOND,
    ST_EXTLEN,
    ST_KEY,
    ST_DATA
  } parse_state_t;

  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic        fin;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] payload_length;
  logic [7:0]  payload_byte;
  logic        frame_end;

  logic [7:0] stream_bytes[$];
  out_word_t  expected_words[$];
  int         bytes_queued = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  logic       holdoff_req = 1'b0;
  int         hold_left = 0;

  int errors = 0;
  int bytes_taken = 0;
  int header_words = 0;
  int data_words = 0;
  int frames_closed = 0;
  int input_stalls = 0;
  int cycles = 0;

  // Decoder state as the design is expected to hold it.
  parse_state_t pstate = ST_FIRST;
  logic         cur_fin = 1'b0;
  logic [3:0]   cur_op = 4'h0;
  logic         cur_masked = 1'b0;
  logic [3:0]   hdr_left = 4'h0;
  logic [63:0]  flen = '0;
  logic [31:0]  key = '0;
  logic [1:0]   key_idx = 2'd0;
  logic [63:0]  remain = '0;

  websocket_frame_decoder_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .fin            (fin),
    .opcode         (opcode),
    .masked         (masked),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .frame_end      (frame_end)
  );

  always #4 clk = ~clk;

  function automatic out_word_t make_word(logic k, logic [7:0] pb, logic e);
    return '{kind: k, fin: cur_fin, opcode: cur_op, masked: cur_masked,
             payload_length: flen, payload_byte: pb, frame_end: e};
  endfunction

  function automatic out_word_t close_header();
    remain = flen;
    key_idx = 2'd0;
    pstate = (flen == 0) ? ST_FIRST : ST_DATA;
    return make_word(wfd_pkg::KIND_HEADER, 8'h00, flen == 0);
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output out_word_t w);
    logic [7:0] kb;
    w = '0;
    case (pstate)
      ST_SECOND: begin
        cur_masked = b[7];
        if (b[6:0] == wfd_pkg::LEN16_CODE || b[6:0] == wfd_pkg::LEN64_CODE) begin
          flen = '0;
          hdr_left = (b[6:0] == wfd_pkg::LEN16_CODE) ? wfd_pkg::EXT16_BYTES
                                                      : wfd_pkg::EXT64_BYTES;
          pstate = ST_EXTLEN;
          return 1'b0;
        end
        flen = {57'd0, b[6:0]};
        if (cur_masked) begin
          hdr_left = wfd_pkg::KEY_BYTES;
          pstate = ST_KEY;
          return 1'b0;
        end
        w = close_header();
        return 1'b1;
      end
      ST_EXTLEN: begin
        flen = {flen[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left != 0) return 1'b0;
        if (cur_masked) begin
          hdr_left = wfd_pkg::KEY_BYTES;
          pstate = ST_KEY;
          return 1'b0;
        end
        w = close_header();
        return 1'b1;
      end
      ST_KEY: begin
        key = {key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left != 0) return 1'b0;
        w = close_header();
        return 1'b1;
      end
      ST_DATA: begin
        kb = key[8 * (3 - key_idx) +: 8];
        key_idx = key_idx + 2'd1;
        remain = remain - 64'd1;
        w = make_word(wfd_pkg::KIND_PAYLOAD, b ^ kb, remain == 0);
        if (remain == 0) pstate = ST_FIRST;
        return 1'b1;
      end
      default: begin
        cur_fin = b[7];
        cur_op = b[3:0];
        cur_masked = 1'b0;
        hdr_left = 4'h0;
        flen = '0;
        key = '0;
        key_idx = 2'd0;
        remain = '0;
        pstate = ST_SECOND;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic string word_str(out_word_t w);
    return $sformatf("kind=%0d fin=%0d op=%h masked=%0d len=%h byte=%h end=%0d",
                     w.kind, w.fin, w.opcode, w.masked, w.payload_length,
                     w.payload_byte, w.frame_end);
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t ERROR: %s", $realtime, msg);
  endtask

  task automatic put(input logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
    bytes_queued++;
  endtask

  task automatic add_frame(input logic [7:0] b0, input logic use_mask,
                           input len_form_t form, input logic [63:0] len);
    put(b0);
    case (form)
      LEN_SHORT: put({use_mask, len[6:0]});
      LEN_EXT16: begin
        put({use_mask, wfd_pkg::LEN16_CODE});
        put(len[15:8]);
        put(len[7:0]);
      end
      default: begin
        put({use_mask, wfd_pkg::LEN64_CODE});
        for (int i = 7; i >= 0; i--) put(len[8 * i +: 8]);
      end
    endcase
    if (use_mask) repeat (4) put(8'($urandom_range(255)));
    for (longint unsigned i = 0; i < len; i++) put(8'($urandom_range(255)));
  endtask

  task automatic add_random_frame();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10)
      add_frame(8'($urandom_range(255)), 1'($urandom_range(1)), LEN_SHORT, 64'd0);
    else if (pick < 71)
      add_frame(8'($urandom_range(255)), 1'($urandom_range(1)), LEN_SHORT,
                64'($urandom_range(12, 1)));
    else if (pick < 74)
      add_frame(8'($urandom_range(255)), 1'($urandom_range(1)), LEN_SHORT,
                64'($urandom_range(125, 100)));
    else if (pick < 85)
      add_frame(8'($urandom_range(255)), 1'($urandom_range(1)), LEN_EXT16,
                64'($urandom_range(20)));
    else if (pick < 86)
      add_frame(8'($urandom_range(255)), 1'($urandom_range(1)), LEN_EXT16,
                64'($urandom_range(300, 256)));
    else
      add_frame(8'($urandom_range(255)), 1'($urandom_range(1)), LEN_EXT64,
                64'($urandom_range(20)));
  endtask

  task automatic run_phase(input int idle_pct, input int busy_pct, input int n,
                           input bit hold);
    int target;
    @(posedge clk);
    send_idle_pct <= idle_pct;
    stall_pct <= busy_pct;
    target = bytes_queued + n;
    while (bytes_queued < target) add_random_frame();
    if (hold) begin
      holdoff_req <= 1'b1;
      @(posedge clk);
      holdoff_req <= 1'b0;
    end
    while (stream_bytes.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      in_byte <= 8'h00;
    end else begin
      if (in_valid && in_stall) input_stalls++;
      if (in_valid && !in_stall) begin
        bytes_taken++;
        if (decode_byte(in_byte, w)) expected_words.insert(expected_words.size(), w);
      end
      if (!in_valid || !in_stall) begin
        if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_byte <= stream_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (holdoff_req) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    out_word_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{kind: kind, fin: fin, opcode: opcode, masked: masked,
              payload_length: payload_length, payload_byte: payload_byte,
              frame_end: frame_end};
      if (kind == wfd_pkg::KIND_HEADER) header_words++;
      else data_words++;
      if (frame_end) frames_closed++;
      if (expected_words.size() == 0) begin
        note_error({"unexpected word: ", word_str(got)});
      end else begin
        exp_w = expected_words.pop_front();
        if (got.kind !== exp_w.kind || got.fin !== exp_w.fin ||
            got.opcode !== exp_w.opcode || got.masked !== exp_w.masked ||
            got.payload_length !== exp_w.payload_length ||
            got.payload_byte !== exp_w.payload_byte ||
            got.frame_end !== exp_w.frame_end)
          note_error({"expected ", word_str(exp_w), " got ", word_str(got)});
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("websocket_frame_decoder_core_tb failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] big_len;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Zero-length frame, then all reserved bits set with a masked payload.
    put(8'h81); put(8'h00);
    put(8'h7F); put({1'b1, 7'd2});
    put(8'hFF); put(8'h00); put(8'hA5); put(8'h5A);
    put(8'hFF); put(8'h0F);
    // Non-minimal 16-bit and 64-bit lengths.
    put(8'h70); put({1'b0, wfd_pkg::LEN16_CODE}); put(8'h00); put(8'h01); put(8'h55);
    put(8'h88); put({1'b0, wfd_pkg::LEN64_CODE});
    repeat (8) put(8'h00);
    while (stream_bytes.size() != 0) @(posedge clk);

    run_phase(0, 0, 50, 1'b0);
    run_phase(80, 0, 50, 1'b0);
    run_phase(0, 80, 50, 1'b0);
    run_phase(30, 30, 50, 1'b0);
    run_phase(0, 0, 50, 1'b1);

    // The last frame carries a 64-bit length with the top bit set and stays open.
    big_len = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
    put(8'h02);
    put({1'b1, wfd_pkg::LEN64_CODE});
    for (int i = 7; i >= 0; i--) put(big_len[8 * i +: 8]);
    repeat (16) put(8'($urandom_range(255)));

    while (stream_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_words.size() != 0)
      note_error($sformatf("%0d words never arrived", expected_words.size()));

    $display("Fed %0d stream bytes; checked %0d header and %0d payload words.",
             bytes_taken, header_words, data_words);
    $display("Frames closed: %0d; input stall cycles: %0d; mismatches: %0d.",
             frames_closed, input_stalls, errors);
    if (errors == 0) begin
      $display("websocket_frame_decoder_core_tb passed");
    end else begin
      $display("websocket_frame_decoder_core_tb failed");
    end
    $finish;
  end

endmodule
